@@ sv/h_bridge_motor_ramp_controller_assert.svh @@
// ----------------------------------------------------------------------------
// H-bridge ramp controller assertion macros
// Concurrent assertion wrappers; defining NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef H_BRIDGE_MOTOR_RAMP_CONTROLLER_ASSERT_SVH
`define H_BRIDGE_MOTOR_RAMP_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define HBMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define HBMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define HBMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HBMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/hbmr_pkg.sv @@
// ----------------------------------------------------------------------------
// H-bridge ramp controller package
// Widths, command codes, sequence phase codes and register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbmr_pkg;

	// Payload widths.
	localparam int OP_W    = 2;
	localparam int SPEED_W = 8;
	localparam int PHASE_W = 3;

	// APB register map.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_RAMP_STEP = 3'd0;
	localparam logic [SPEED_W-1:0] RAMP_STEP_RESET = 8'd5;

	// Command codes.
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_SPEED   = 2'd1;
	localparam logic [OP_W-1:0] OP_POWER   = 2'd2;
	localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

	// Sequence phases.
	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_RAMP  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_STOP  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RDOWN = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RUP   = 3'd4;

endpackage

`default_nettype wire

@@ sv/hbmr_if.sv @@
// ----------------------------------------------------------------------------
// H-bridge ramp controller channels
// Valid/ready interfaces for the command channel and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hbmr_cmd_if;
	import hbmr_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [SPEED_W-1:0] target_speed;

	modport source (output valid, output op, output target_speed, input ready);
	modport sink   (input valid, input op, input target_speed, output ready);
endinterface

interface hbmr_res_if;
	import hbmr_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] duty;
	logic               drive_a;
	logic               drive_b;
	logic               power_on;
	logic               busy_res;
	logic               accepted;

	modport source (
		output valid, output duty, output drive_a, output drive_b,
		output power_on, output busy_res, output accepted, input ready
	);
	modport sink (
		input valid, input duty, input drive_a, input drive_b,
		input power_on, input busy_res, input accepted, output ready
	);
endinterface

`default_nettype wire

@@ sv/h_bridge_motor_ramp_controller.sv @@
// ----------------------------------------------------------------------------
// H-bridge motor ramp controller
// Slew-limited PWM duty with power and direction sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one beat per command (op, target_speed); res returns exactly
//   one beat per command with the duty, bridge pins and status after it.
//   ramp_step is written over the APB port at byte address 0 while idle;
//   a value of zero acts as one.
// Latency and throughput:
//   A command is decoded and the motor state updated in the cycle it is
//   accepted; its result beat appears on res in the next cycle. The whole
//   update is one compare-and-add slew step, so one beat is taken every
//   cycle while the result register is not held full by res.ready low.
// Reset:
//   Duty, goal and saved speed clear to zero, direction is clockwise, power
//   is off, no sequence runs, and ramp_step returns to 5.
// Stall:
//   A single result register holds the pending beat. While it is full and
//   res.ready is low, cmd.ready is low; it rises in the cycle res drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "h_bridge_motor_ramp_controller_assert.svh"

module h_bridge_motor_ramp_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	hbmr_cmd_if.sink                         cmd,
	hbmr_res_if.source                       res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hbmr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [hbmr_pkg::PDATA_W-1:0] pwdata,
	output logic      [hbmr_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import hbmr_pkg::*;

	// Configuration and motor state.
	logic [SPEED_W-1:0] ramp_step_q;
	logic [SPEED_W-1:0] speed_now_q;
	logic [SPEED_W-1:0] speed_goal_q;
	logic [SPEED_W-1:0] speed_saved_q;
	logic               direction_q;
	logic               powered_q;
	logic [PHASE_W-1:0] phase_q;

	// Result register.
	logic               res_valid_q;
	logic [SPEED_W-1:0] duty_q;
	logic               drive_a_q;
	logic               drive_b_q;
	logic               power_on_q;
	logic               busy_res_q;
	logic               accepted_q;

	// Next-state values.
	logic               cmd_fire;
	logic               busy;
	logic               do_adv;
	logic               accept_cmd;
	logic [PHASE_W-1:0] pre_phase;
	logic [SPEED_W-1:0] pre_goal;
	logic [SPEED_W-1:0] saved_nxt;
	logic               powered_nxt;
	logic [SPEED_W-1:0] step;
	logic [SPEED_W-1:0] dist_up;
	logic [SPEED_W-1:0] dist_dn;
	logic [SPEED_W-1:0] slew_now;
	logic               reached;
	logic [SPEED_W-1:0] now_nxt;
	logic [SPEED_W-1:0] goal_nxt;
	logic               dir_nxt;
	logic [PHASE_W-1:0] phase_nxt;
	logic               drive;

	// APB register access; pready is tied high.
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_RAMP_STEP) begin
			prdata = {{(PDATA_W-SPEED_W){1'b0}}, ramp_step_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= RAMP_STEP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_RAMP_STEP) begin
			ramp_step_q <= pwdata[SPEED_W-1:0];
		end
	end

	// Handshake: the result register frees up when it is empty or draining.
	assign cmd.ready = !res_valid_q || res.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign busy      = (phase_q == PH_RAMP) || (phase_q == PH_STOP) ||
	                   (phase_q == PH_RDOWN) || (phase_q == PH_RUP);

	// Command decode: choose the goal and phase the slew step starts from.
	always_comb begin
		pre_phase   = phase_q;
		pre_goal    = speed_goal_q;
		saved_nxt   = speed_saved_q;
		powered_nxt = powered_q;
		do_adv      = 1'b0;
		accept_cmd  = 1'b1;
		if (cmd.op == OP_TICK) begin
			if (busy) begin
				do_adv = 1'b1;
			end else begin
				pre_phase = PH_IDLE;
			end
		end else if (busy) begin
			accept_cmd = 1'b0;
		end else begin
			unique case (cmd.op)
				OP_SPEED: begin
					pre_goal  = cmd.target_speed;
					pre_phase = PH_RAMP;
					do_adv    = 1'b1;
				end
				OP_POWER: begin
					powered_nxt = !powered_q;
					if (!powered_q) begin
						pre_phase = PH_IDLE;
					end else begin
						pre_goal  = '0;
						pre_phase = PH_STOP;
						do_adv    = 1'b1;
					end
				end
				OP_REVERSE: begin
					saved_nxt = speed_now_q;
					pre_goal  = '0;
					pre_phase = PH_RDOWN;
					do_adv    = 1'b1;
				end
				default: begin
					pre_phase = PH_IDLE;
				end
			endcase
		end
	end

	// One slew step of at most ramp_step (one if it is zero) toward the goal, snapping when close.
	assign step    = (ramp_step_q == '0) ? {{(SPEED_W-1){1'b0}}, 1'b1} : ramp_step_q;
	assign dist_up = pre_goal - speed_now_q;
	assign dist_dn = speed_now_q - pre_goal;
	always_comb begin
		if (speed_now_q < pre_goal) begin
			slew_now = (dist_up > step) ? speed_now_q + step : pre_goal;
		end else if (speed_now_q > pre_goal) begin
			slew_now = (dist_dn > step) ? speed_now_q - step : pre_goal;
		end else begin
			slew_now = speed_now_q;
		end
	end
	assign reached = (slew_now == pre_goal);

	// Phase sequencing after the slew step.
	always_comb begin
		now_nxt   = speed_now_q;
		goal_nxt  = pre_goal;
		dir_nxt   = direction_q;
		phase_nxt = pre_phase;
		if (do_adv) begin
			now_nxt = slew_now;
			unique case (pre_phase)
				PH_RAMP, PH_STOP, PH_RUP: begin
					if (reached) begin
						phase_nxt = PH_IDLE;
					end
				end
				PH_RDOWN: begin
					if (reached) begin
						dir_nxt   = !direction_q;
						goal_nxt  = saved_nxt;
						phase_nxt = PH_RUP;
					end
				end
				default: begin
					phase_nxt = PH_IDLE;
				end
			endcase
		end
	end

	// The pins are driven while powered, and during the stop ramp.
	assign drive = powered_nxt || (phase_nxt == PH_STOP);

	// Motor state update on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_now_q   <= '0;
			speed_goal_q  <= '0;
			speed_saved_q <= '0;
			direction_q   <= 1'b0;
			powered_q     <= 1'b0;
			phase_q       <= PH_IDLE;
		end else if (cmd_fire) begin
			speed_now_q   <= now_nxt;
			speed_goal_q  <= goal_nxt;
			speed_saved_q <= saved_nxt;
			direction_q   <= dir_nxt;
			powered_q     <= powered_nxt;
			phase_q       <= phase_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with each accepted beat.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			duty_q     <= now_nxt;
			drive_a_q  <= drive && dir_nxt;
			drive_b_q  <= drive && !dir_nxt;
			power_on_q <= powered_nxt;
			busy_res_q <= (phase_nxt != PH_IDLE);
			accepted_q <= accept_cmd;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.duty     = duty_q;
	assign res.drive_a  = drive_a_q;
	assign res.drive_b  = drive_b_q;
	assign res.power_on = power_on_q;
	assign res.busy_res = busy_res_q;
	assign res.accepted = accepted_q;

	// With no sequence running the duty sits at its goal.
	`HBMR_ASSERT_IMPLY(a_idle_at_goal, clk, arst_n, phase_q == PH_IDLE, speed_now_q == speed_goal_q)
	// The reverse ramp-down always heads for zero duty.
	`HBMR_ASSERT_IMPLY(a_rdown_goal_zero, clk, arst_n, phase_q == PH_RDOWN, speed_goal_q == '0)
	// A command refused because busy leaves the motor state untouched.
	`HBMR_ASSERT_NEXT(a_refused_stable, clk, arst_n, cmd_fire && busy && cmd.op != OP_TICK, $stable(speed_now_q) && $stable(powered_q) && $stable(direction_q) && $stable(phase_q))
	// The bridge is never driven in both directions at once.
	`HBMR_ASSERT_IMPLY(a_pins_exclusive, clk, arst_n, res_valid_q, !(drive_a_q && drive_b_q))

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H-bridge motor ramp controller testbench
// Drives command beats with random gaps and two long result back-pressure
// stretches. Each accepted command is run through a cycle-free model of the
// duty slew, power and reverse sequencing. The model's status is compared,
// field by field, with the result beat. The ramp step is swept across
// several values, the extremes among them, over the APB port and read back.
// ----------------------------------------------------------------------------

module tb_top;
	import hbmr_pkg::*;

	// One result beat as seen on the result channel.
	typedef struct packed {
		logic [SPEED_W-1:0] duty;
		logic               drive_a;
		logic               drive_b;
		logic               power_on;
		logic               busy_res;
		logic               accepted;
	} motor_status_t;

	// Predicts the status after each command and holds it until its beat arrives.
	class motor_scoreboard;
		logic [SPEED_W-1:0] ramp_step;
		logic [SPEED_W-1:0] duty_now;
		logic [SPEED_W-1:0] duty_goal;
		logic [SPEED_W-1:0] duty_saved;
		logic               anticlockwise;
		logic               powered;
		logic [PHASE_W-1:0] phase;
		motor_status_t      expected_status[$];
		int unsigned        errors;

		function new();
			ramp_step     = RAMP_STEP_RESET;
			duty_now      = '0;
			duty_goal     = '0;
			duty_saved    = '0;
			anticlockwise = 1'b0;
			powered       = 1'b0;
			phase         = PH_IDLE;
			errors        = 0;
		endfunction

		function void set_step(logic [SPEED_W-1:0] value);
			ramp_step = value;
		endfunction

		function bit sequence_running();
			return phase != PH_IDLE;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		// One slew step toward the goal; a zero step behaves as one.
		function bit slew_toward_goal();
			logic [SPEED_W-1:0] step;
			step = (ramp_step == '0) ? 8'd1 : ramp_step;
			if (duty_now < duty_goal) begin
				if (duty_goal - duty_now > step)
					duty_now = duty_now + step;
				else
					duty_now = duty_goal;
			end else if (duty_now > duty_goal) begin
				if (duty_now - duty_goal > step)
					duty_now = duty_now - step;
				else
					duty_now = duty_goal;
			end
			return duty_now == duty_goal;
		endfunction

		// Moves the running sequence on by one step.
		function void advance_sequence();
			case (phase)
				PH_RAMP, PH_STOP, PH_RUP: begin
					if (slew_toward_goal())
						phase = PH_IDLE;
				end
				PH_RDOWN: begin
					if (slew_toward_goal()) begin
						anticlockwise = ~anticlockwise;
						duty_goal     = duty_saved;
						phase         = PH_RUP;
					end
				end
				default: phase = PH_IDLE;
			endcase
		endfunction

		// Applies one accepted command and queues the status it should produce.
		function void note_command(logic [OP_W-1:0] op, logic [SPEED_W-1:0] target);
			motor_status_t status;
			bit            was_busy;
			bit            driven;
			was_busy        = sequence_running();
			status.accepted = 1'b1;
			if (op == OP_TICK) begin
				if (was_busy)
					advance_sequence();
			end else if (was_busy) begin
				status.accepted = 1'b0;
			end else if (op == OP_SPEED) begin
				duty_goal = target;
				phase     = PH_RAMP;
				advance_sequence();
			end else if (op == OP_POWER) begin
				powered = ~powered;
				if (!powered) begin
					duty_goal = '0;
					phase     = PH_STOP;
					advance_sequence();
				end
			end else begin
				duty_saved = duty_now;
				duty_goal  = '0;
				phase      = PH_RDOWN;
				advance_sequence();
			end
			driven          = powered || (phase == PH_STOP);
			status.duty     = duty_now;
			status.drive_a  = driven && anticlockwise;
			status.drive_b  = driven && !anticlockwise;
			status.power_on = powered;
			status.busy_res = (phase != PH_IDLE);
			expected_status.push_back(status);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Checks one result beat against the oldest prediction.
		function void check_status(motor_status_t got);
			motor_status_t want;
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_status.pop_front();
			compare_field("duty", want.duty, got.duty);
			compare_field("drive_a", want.drive_a, got.drive_a);
			compare_field("drive_b", want.drive_b, got.drive_b);
			compare_field("power_on", want.power_on, got.power_on);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("accepted", want.accepted, got.accepted);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	hbmr_cmd_if cmd_ch ();
	hbmr_res_if res_ch ();

	motor_scoreboard motor_sb = new();
	int unsigned     commands_sent;
	int unsigned     results_seen;

	h_bridge_motor_ramp_controller u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offers one command beat and returns at the edge where it is taken.
	task automatic send_command(input logic [OP_W-1:0] op, input logic [SPEED_W-1:0] target);
		bit steady;
		steady = (commands_sent >= 400 && commands_sent < 600);
		while (!steady && $urandom_range(99) < 9) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.op           <= op;
		cmd_ch.target_speed <= target;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		motor_sb.note_command(op, target);
		commands_sent++;
	endtask

	// Ticks until the predicted sequence has ended.
	task automatic finish_sequence();
		while (motor_sb.sequence_running())
			send_command(OP_TICK, 8'($urandom));
	endtask

	// Stops offering and waits for every outstanding result beat.
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (motor_sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the ramp step over APB, then reads it back.
	task automatic configure_ramp_step(input logic [SPEED_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_RAMP_STEP;
		pwdata  <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		motor_sb.set_step(value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[SPEED_W-1:0] !== value) begin
			$display("%0t: ramp_step read-back mismatch, expected %0d, actual %0d",
				$time, value, prdata[SPEED_W-1:0]);
			motor_sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Target duty weighted toward the extremes.
	function automatic logic [SPEED_W-1:0] random_speed();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		return 8'($urandom_range(255));
	endfunction

	// Mostly complete sequences with random content, some cut short, with noise.
	task automatic run_random_phase(input int unsigned item_count);
		int unsigned     first;
		int unsigned     r;
		int unsigned     tick_limit;
		int unsigned     ticks;
		logic [OP_W-1:0] op;
		first = commands_sent;
		while (commands_sent - first < item_count) begin
			r = $urandom_range(99);
			if (r < 50)
				op = OP_SPEED;
			else if (r < 72)
				op = OP_POWER;
			else if (r < 92)
				op = OP_REVERSE;
			else
				op = OP_TICK;
			send_command(op, random_speed());
			tick_limit = ($urandom_range(99) < 15) ? $urandom_range(6) : 100000;
			ticks      = 0;
			while (motor_sb.sequence_running() && ticks < tick_limit) begin
				if ($urandom_range(99) < 8) begin
					send_command(OP_W'($urandom_range(3, 1)), random_speed());
				end else begin
					send_command(OP_TICK, 8'($urandom));
					ticks++;
				end
			end
			if ($urandom_range(99) < 10)
				send_command(OP_TICK, 8'($urandom));
		end
	endtask

	// Result sink: random back-pressure, two long holds, one steady stretch.
	initial begin : result_sink
		int unsigned   hold;
		motor_status_t got;
		hold         = 0;
		results_seen = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.duty     = res_ch.duty;
				got.drive_a  = res_ch.drive_a;
				got.drive_b  = res_ch.drive_b;
				got.power_on = res_ch.power_on;
				got.busy_res = res_ch.busy_res;
				got.accepted = res_ch.accepted;
				motor_sb.check_status(got);
				results_seen++;
				if (results_seen == 250 || results_seen == 800)
					hold = 60;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (results_seen >= 400 && results_seen < 600) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= 9);
			end
		end
	end

	// Main sequence: reset, directed cases, then random phases per step value.
	initial begin : stimulus
		logic [SPEED_W-1:0] step_plan[5];
		commands_sent       = 0;
		arst_n              <= 1'b0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.op           <= OP_TICK;
		cmd_ch.target_speed <= '0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= ADDR_RAMP_STEP;
		pwdata              <= '0;
		step_plan[0]        = 8'd1;
		step_plan[1]        = 8'd255;
		step_plan[2]        = 8'd0;
		step_plan[3]        = 8'($urandom_range(254, 2));
		step_plan[4]        = 8'($urandom_range(254, 2));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle tick, then a ramp while unpowered with commands ignored as busy.
		send_command(OP_TICK, 8'hA5);
		send_command(OP_SPEED, 8'd12);
		send_command(OP_POWER, 8'd0);
		send_command(OP_REVERSE, 8'd0);
		send_command(OP_SPEED, 8'd200);
		finish_sequence();
		// Power-on leaves the duty alone; then a short ramp while powered.
		send_command(OP_POWER, 8'd0);
		send_command(OP_SPEED, 8'd20);
		finish_sequence();
		// Full reverse: down to zero, flip, back up to the saved duty.
		send_command(OP_REVERSE, 8'd0);
		finish_sequence();
		// Power-off stop ramp, pins released at zero.
		send_command(OP_POWER, 8'd0);
		finish_sequence();
		// Reverse at zero duty while off.
		send_command(OP_SPEED, 8'd0);
		send_command(OP_REVERSE, 8'd0);
		finish_sequence();
		run_random_phase(170);
		drain_results();

		foreach (step_plan[i]) begin
			configure_ramp_step(step_plan[i]);
			// Full-scale jumps snap in one step at the widest setting.
			if (step_plan[i] == 8'd255) begin
				send_command(OP_SPEED, 8'd255);
				send_command(OP_SPEED, 8'd0);
				send_command(OP_POWER, 8'd0);
			end
			run_random_phase(170);
			drain_results();
		end

		if (motor_sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/hbmr_pkg.sv
sv/hbmr_if.sv
sv/h_bridge_motor_ramp_controller.sv
dv/tb_top.sv
